// File: hdl/q2e_pkg.sv
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle converter. No dependencies.
package q2e_pkg;

  localparam int QW = 16;
  localparam int PW = 2 * QW;
  localparam int SW = 36;
  localparam int MW = 28;
  localparam int VW = 57;
  localparam int TW = 59;
  localparam int RW = 29;
  localparam int CW = 38;
  localparam int AW = 29;
  localparam int MAX_STAGES = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int RND_SHIFT = 11;

  localparam logic signed [SW-1:0] ONE_Q28 = SW'(64'sd268435456);
  localparam logic signed [AW-1:0] PI_Q24 = AW'(64'sd52707179);
  localparam logic signed [QW-1:0] PI_Q13 = QW'(64'sd25736);
  localparam logic signed [QW-2:0] HALF_PI_Q13 = (QW-1)'(64'sd12868);

  typedef struct packed {
    logic clamp;
    logic pos;
    logic signed [SW-1:0] sinr;
    logic signed [SW-1:0] cosr;
    logic signed [SW-1:0] sinp;
    logic signed [SW-1:0] siny;
    logic signed [SW-1:0] cosy;
  } carry_t;

  function automatic logic signed [AW-1:0] atan_q24(input int idx);
    logic signed [AW-1:0] r;
    case (idx)
      0: r = AW'(64'sd13176795);
      1: r = AW'(64'sd7778716);
      2: r = AW'(64'sd4110060);
      3: r = AW'(64'sd2086331);
      4: r = AW'(64'sd1047214);
      5: r = AW'(64'sd524117);
      6: r = AW'(64'sd262123);
      7: r = AW'(64'sd131069);
      8: r = AW'(64'sd65536);
      9: r = AW'(64'sd32768);
      10: r = AW'(64'sd16384);
      11: r = AW'(64'sd8192);
      12: r = AW'(64'sd4096);
      13: r = AW'(64'sd2048);
      14: r = AW'(64'sd1024);
      15: r = AW'(64'sd512);
      16: r = AW'(64'sd256);
      17: r = AW'(64'sd128);
      18: r = AW'(64'sd64);
      19: r = AW'(64'sd32);
      20: r = AW'(64'sd16);
      21: r = AW'(64'sd8);
      22: r = AW'(64'sd4);
      23: r = AW'(64'sd2);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/q2e_cordic.sv
// Pipelined vectoring CORDIC: atan2(y, x) in units of 2^-24 rad.
// Depends on q2e_pkg. One prescale stage, then one stage per rotation.
module q2e_cordic #(
  parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [q2e_pkg::CW-1:0]    y_in,
  input  logic signed [q2e_pkg::CW-1:0]    x_in,
  output logic signed [q2e_pkg::AW-1:0]    z_out
);

  localparam int NS = (STAGES < q2e_pkg::MAX_STAGES) ? STAGES : q2e_pkg::MAX_STAGES;

  logic signed [q2e_pkg::CW-1:0] xs [0:NS];
  logic signed [q2e_pkg::CW-1:0] ys [0:NS];
  logic signed [q2e_pkg::AW-1:0] zs [0:NS];
  logic                          zf [0:NS];

  always_ff @(posedge clk) begin
    if (en) begin
      zf[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= (y_in >= 0) ? q2e_pkg::PI_Q24 : -q2e_pkg::PI_Q24;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + q2e_pkg::atan_q24(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - q2e_pkg::atan_q24(i);
        end
      end
    end
  end

  assign z_out = zf[NS] ? '0 : zs[NS];

endmodule

// File: hdl/quaternion_to_euler.sv
// Quaternion (Q1.14) to roll, pitch, yaw (Q3.13 rad), fully pipelined.
// Depends on q2e_pkg and q2e_cordic.
//
//   channel  valid      stall      payload
//   input    in_valid   in_stall   quat_x quat_y quat_z quat_w
//   output   out_valid  out_stall  roll_angle pitch_angle yaw_angle pitch_clamped
//
// One beat per cycle while the skid register is empty. The stages, in order:
// products, sums, square, radicand, one square-root bit per stage, the CORDIC
// prescale and rotations, rounding. A skid register at the output holds one beat during a
// stall; the pipeline freezes while it is full. rst clears the valid bits only.
module quaternion_to_euler #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [15:0]       quat_x,
  input  logic signed [15:0]       quat_y,
  input  logic signed [15:0]       quat_z,
  input  logic signed [15:0]       quat_w,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [15:0]       roll_angle,
  output logic signed [14:0]       pitch_angle,
  output logic signed [15:0]       yaw_angle,
  output logic                     pitch_clamped
);

  localparam int NS = (CORDIC_STAGES < q2e_pkg::MAX_STAGES) ?
                      CORDIC_STAGES : q2e_pkg::MAX_STAGES;
  localparam int CL = NS + 1;
  localparam int SW = q2e_pkg::SW;
  localparam int PW = q2e_pkg::PW;
  localparam int RW = q2e_pkg::RW;
  localparam int VW = q2e_pkg::VW;
  localparam int TW = q2e_pkg::TW;
  localparam int MW = q2e_pkg::MW;
  localparam int AW = q2e_pkg::AW;
  localparam int CW = q2e_pkg::CW;
  localparam int OW = AW + 1 - q2e_pkg::RND_SHIFT;

  logic en;
  logic skid_v;

  assign en = !skid_v;
  assign in_stall = skid_v;

  // products
  logic v1;
  logic signed [PW-1:0] p_wx, p_yz, p_xx, p_yy, p_zz, p_wy, p_zx, p_wz, p_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= quat_w * quat_x;
      p_yz <= quat_y * quat_z;
      p_xx <= quat_x * quat_x;
      p_yy <= quat_y * quat_y;
      p_zz <= quat_z * quat_z;
      p_wy <= quat_w * quat_y;
      p_zx <= quat_z * quat_x;
      p_wz <= quat_w * quat_z;
      p_xy <= quat_x * quat_y;
    end
  end

  // sums
  q2e_pkg::carry_t c2_next, c2;
  logic [MW-1:0] mag_next, mag2;
  logic signed [SW-1:0] sinp_abs;
  logic v2;

  always_comb begin
    c2_next.sinr = (SW'(p_wx) + SW'(p_yz)) <<< 1;
    c2_next.cosr = q2e_pkg::ONE_Q28 - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
    c2_next.sinp = (SW'(p_wy) - SW'(p_zx)) <<< 1;
    c2_next.siny = (SW'(p_wz) + SW'(p_xy)) <<< 1;
    c2_next.cosy = q2e_pkg::ONE_Q28 - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
    c2_next.clamp = (c2_next.sinp >= q2e_pkg::ONE_Q28) ||
                    (c2_next.sinp <= -q2e_pkg::ONE_Q28);
    c2_next.pos = c2_next.sinp > 0;
    sinp_abs = (c2_next.sinp < 0) ? -c2_next.sinp : c2_next.sinp;
    mag_next = c2_next.clamp ? '0 : sinp_abs[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
      mag2 <= mag_next;
    end
  end

  // square and radicand
  logic v3;
  q2e_pkg::carry_t c3;
  logic [2*MW-1:0] msq;

  logic sq_v [0:RW];
  q2e_pkg::carry_t sq_c [0:RW];
  logic [VW-1:0] sq_rem [0:RW];
  logic [RW-1:0] sq_root [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      sq_v[0] <= 1'b0;
    end else if (en) begin
      v3 <= v2;
      sq_v[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      msq <= mag2 * mag2;
      sq_c[0] <= c3;
      sq_rem[0] <= (VW'(1) << (2 * MW)) - VW'(msq);
      sq_root[0] <= '0;
    end
  end

  // square root, one root bit per stage
  for (genvar j = 0; j < RW; j++) begin : g_sqrt
    localparam int K = RW - 1 - j;
    logic [TW-1:0] test;
    logic ge;

    assign test = (TW'(sq_root[j]) << (K + 1)) | (TW'(1) << (2 * K));
    assign ge = TW'(sq_rem[j]) >= test;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[j+1] <= 1'b0;
      end else if (en) begin
        sq_v[j+1] <= sq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[j+1] <= sq_c[j];
        sq_rem[j+1] <= ge ? VW'(TW'(sq_rem[j]) - test) : sq_rem[j];
        sq_root[j+1] <= ge ? (sq_root[j] | (RW'(1) << K)) : sq_root[j];
      end
    end
  end

  // arctangents
  logic signed [AW-1:0] z_roll, z_pitch, z_yaw;

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_c[RW].sinr)),
    .x_in  (CW'(sq_c[RW].cosr)),
    .z_out (z_roll)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_c[RW].sinp)),
    .x_in  (CW'($signed({1'b0, sq_root[RW]}))),
    .z_out (z_pitch)
  );

  q2e_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(sq_c[RW].siny)),
    .x_in  (CW'(sq_c[RW].cosy)),
    .z_out (z_yaw)
  );

  logic cd_v [0:CL];
  logic cd_clamp [0:CL];
  logic cd_pos [0:CL];

  assign cd_v[0] = sq_v[RW];
  assign cd_clamp[0] = sq_c[RW].clamp;
  assign cd_pos[0] = sq_c[RW].pos;

  for (genvar d = 0; d < CL; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        cd_v[d+1] <= 1'b0;
      end else if (en) begin
        cd_v[d+1] <= cd_v[d];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_clamp[d+1] <= cd_clamp[d];
        cd_pos[d+1] <= cd_pos[d];
      end
    end
  end

  // round and saturate
  logic signed [OW-1:0] rr, rp, ry;
  logic signed [15:0] roll_next, yaw_next;
  logic signed [14:0] pitch_next;

  always_comb begin
    rp = OW'(((AW+1)'(z_pitch) + (AW+1)'(1024)) >>> q2e_pkg::RND_SHIFT);
    ry = OW'(((AW+1)'(z_yaw) + (AW+1)'(1024)) >>> q2e_pkg::RND_SHIFT);
    rr = OW'(((AW+1)'(z_roll) + (AW+1)'(1024)) >>> q2e_pkg::RND_SHIFT);
    if (rr > OW'(q2e_pkg::PI_Q13)) begin
      roll_next = q2e_pkg::PI_Q13;
    end else if (rr < -OW'(q2e_pkg::PI_Q13)) begin
      roll_next = -q2e_pkg::PI_Q13;
    end else begin
      roll_next = 16'(rr);
    end
    if (ry > OW'(q2e_pkg::PI_Q13)) begin
      yaw_next = q2e_pkg::PI_Q13;
    end else if (ry < -OW'(q2e_pkg::PI_Q13)) begin
      yaw_next = -q2e_pkg::PI_Q13;
    end else begin
      yaw_next = 16'(ry);
    end
    if (cd_clamp[CL]) begin
      pitch_next = cd_pos[CL] ? q2e_pkg::HALF_PI_Q13 : -q2e_pkg::HALF_PI_Q13;
    end else if (rp > OW'(q2e_pkg::HALF_PI_Q13)) begin
      pitch_next = q2e_pkg::HALF_PI_Q13;
    end else if (rp < -OW'(q2e_pkg::HALF_PI_Q13)) begin
      pitch_next = -q2e_pkg::HALF_PI_Q13;
    end else begin
      pitch_next = 15'(rp);
    end
  end

  logic v_last;
  logic signed [15:0] last_roll, last_yaw, skid_roll, skid_yaw;
  logic signed [14:0] last_pitch, skid_pitch;
  logic last_clamp, skid_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_last <= 1'b0;
    end else if (en) begin
      v_last <= cd_v[CL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      last_roll <= roll_next;
      last_pitch <= pitch_next;
      last_yaw <= yaw_next;
      last_clamp <= cd_clamp[CL];
    end
  end

  // skid: hold one beat while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (skid_v && !out_stall) begin
      skid_v <= 1'b0;
    end else if (!skid_v && v_last && out_stall) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v) begin
      skid_roll <= last_roll;
      skid_pitch <= last_pitch;
      skid_yaw <= last_yaw;
      skid_clamp <= last_clamp;
    end
  end

  assign out_valid = skid_v || v_last;
  assign roll_angle = skid_v ? skid_roll : last_roll;
  assign pitch_angle = skid_v ? skid_pitch : last_pitch;
  assign yaw_angle = skid_v ? skid_yaw : last_yaw;
  assign pitch_clamped = skid_v ? skid_clamp : last_clamp;

endmodule
